FILE: design/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

  // Field widths
  localparam int BASE_BITS = 31;
  localparam int EXP_BITS  = 31;
  localparam int MOD_BITS  = 27;

  // Multiplier operand B is wide enough for the raw base as well as a residue
  localparam int OPB_BITS  = (BASE_BITS > MOD_BITS) ? BASE_BITS : MOD_BITS;
  localparam int CNT_BITS  = $clog2(OPB_BITS + 1);

  typedef logic [MOD_BITS-1:0]  mod_t;
  typedef logic [OPB_BITS-1:0]  opb_t;
  typedef logic [EXP_BITS-1:0]  exp_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  localparam mod_t MODULUS_RESET = MOD_BITS'(100000007);

  // Request to the shared modular multiplier
  typedef struct packed {
    logic start;
    mod_t a;      // multiplicand, below the modulus
    opb_t b;      // multiplier, MSB-aligned to bit OPB_BITS-1
    cnt_t steps;  // number of multiplier bits to scan
    mod_t m;      // modulus
  } mul_req_t;

  // Status back from the multiplier
  typedef struct packed {
    logic done;   // one-cycle pulse, result valid
    mod_t result;
  } mul_stat_t;

endpackage

FILE: design/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
module mexp_mulmod (
  input  logic                clk,
  input  logic                rst,
  input  mexp_pkg::mul_req_t  req,
  output mexp_pkg::mul_stat_t stat
);

  logic                         busy;
  logic                         done;
  mexp_pkg::mod_t               r;
  mexp_pkg::mod_t               a;
  mexp_pkg::mod_t               m;
  mexp_pkg::opb_t               bsh;
  mexp_pkg::cnt_t               cnt;

  logic [mexp_pkg::MOD_BITS:0]  dbl;
  logic [mexp_pkg::MOD_BITS:0]  m_ext;
  mexp_pkg::mod_t               r2;
  logic [mexp_pkg::MOD_BITS:0]  sum;
  mexp_pkg::mod_t               r_next;

  // One step: r = (2r + bit*a) mod m, each half with one conditional subtract
  always_comb begin
    m_ext = {1'b0, m};
    dbl   = {r, 1'b0};
    r2    = (dbl >= m_ext) ? mexp_pkg::MOD_BITS'(dbl - m_ext)
                           : mexp_pkg::MOD_BITS'(dbl);
    sum   = {1'b0, r2} + (bsh[mexp_pkg::OPB_BITS-1] ? {1'b0, a}
                                                    : {(mexp_pkg::MOD_BITS+1){1'b0}});
    r_next = (sum >= m_ext) ? mexp_pkg::MOD_BITS'(sum - m_ext)
                            : mexp_pkg::MOD_BITS'(sum);
  end

  // Sequencing of the bit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        r    <= '0;
        a    <= req.a;
        m    <= req.m;
        bsh  <= req.b;
        cnt  <= req.steps;
      end else if (busy) begin
        r   <= r_next;
        bsh <= {bsh[mexp_pkg::OPB_BITS-2:0], 1'b0};
        cnt <= cnt - mexp_pkg::CNT_BITS'(1);
        if (cnt == mexp_pkg::CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done   = done;
  assign stat.result = r;

endmodule

FILE: design/modular_exponentiation.sv
// Top level: square-and-multiply sequencer around a shared modular multiplier.
//
// Usage: a request on the input channel (in_valid/in_ready) carries base and
// exponent; exactly one result, power_mod = base^exponent mod modulus, leaves
// on the output channel (out_valid/out_ready). Both channels take a request
// at a clock edge where valid and ready are both high.
// The user must write the modulus register (modulus_wr_en/modulus_wr_data)
// only while the block is idle; this is not enforced. Reset loads 100000007.
// Work is one request at a time: in_ready is high only when idle.
// Operation: the base is first reduced by a 31-step multiplier pass, then each
// exponent bit below the highest set one costs a squaring and each set bit a
// multiply, each a 27-step multiplier pass with sequencing between passes.
// Worst case (all 31 exponent bits set) is 61 products from accept to
// out_valid; exponent zero takes only the reduction pass, and a modulus below
// two none. With a ready receiver the block returns to idle once the result
// is taken and can then accept the next request.
// A stalled receiver holds power_mod and out_valid until taken; no new
// request is accepted until then. Synchronous reset (rst) clears the
// sequencer and drops out_valid.
module modular_exponentiation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mexp_pkg::BASE_BITS-1:0]      base,
  input  logic [mexp_pkg::EXP_BITS-1:0]       exponent,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mexp_pkg::MOD_BITS-1:0]       power_mod,
  input  logic                                modulus_wr_en,
  input  logic [mexp_pkg::MOD_BITS-1:0]       modulus_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

  localparam int ALIGN = mexp_pkg::OPB_BITS - mexp_pkg::MOD_BITS;

  state_t              state;
  mexp_pkg::mod_t      modulus;
  mexp_pkg::mod_t      m_cur;
  mexp_pkg::mod_t      acc;
  mexp_pkg::mod_t      sq;
  mexp_pkg::exp_t      e;
  mexp_pkg::mul_req_t  req;
  mexp_pkg::mul_stat_t stat;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mexp_pkg::MODULUS_RESET;
    end else if (modulus_wr_en) begin
      modulus <= modulus_wr_data;
    end
  end

  // Shared modular multiplier
  mexp_mulmod u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat)
  );

  // Sequencer: state, operands and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      req.start <= 1'b0;
    end else begin
      req.start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            m_cur <= modulus;
            e     <= exponent;
            if (modulus < mexp_pkg::MOD_BITS'(2)) begin
              power_mod <= '0;
              out_valid <= 1'b1;
              state     <= ST_DONE;
            end else begin
              // reduce the base: 1 * base mod m
              req.start <= 1'b1;
              req.a     <= mexp_pkg::MOD_BITS'(1);
              req.b     <= mexp_pkg::OPB_BITS'(base);
              req.steps <= mexp_pkg::CNT_BITS'(mexp_pkg::BASE_BITS);
              req.m     <= modulus;
              state     <= ST_RED;
            end
          end
        end
        ST_RED: begin
          if (stat.done) begin
            sq    <= stat.result;
            acc   <= mexp_pkg::MOD_BITS'(1);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          req.steps <= mexp_pkg::CNT_BITS'(mexp_pkg::MOD_BITS);
          req.m     <= m_cur;
          req.b     <= mexp_pkg::OPB_BITS'(sq) << ALIGN;
          if (e == '0) begin
            power_mod <= acc;
            out_valid <= 1'b1;
            state     <= ST_DONE;
          end else if (e[0]) begin
            req.start <= 1'b1;
            req.a     <= acc;
            state     <= ST_MUL;
          end else begin
            req.start <= 1'b1;
            req.a     <= sq;
            state     <= ST_SQR;
          end
        end
        ST_MUL: begin
          if (stat.done) begin
            acc   <= stat.result;
            e[0]  <= 1'b0;
            state <= ST_CHECK;
          end
        end
        ST_SQR: begin
          if (stat.done) begin
            sq    <= stat.result;
            e     <= e >> 1;
            state <= ST_CHECK;
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

endmodule

FILE: tb/sv/modular_exponentiation_tb.sv
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 100ps

module modular_exponentiation_tb;

  typedef logic [mexp_pkg::BASE_BITS-1:0] base_t;

  localparam mexp_pkg::mod_t MODULUS_MAX = '1;
  localparam int   TAIL_CYCLES = 2000;  // a little over the worst-case latency
  localparam int   LONG_HOLD   = 3000;  // longer than one full exponentiation

  // DUT ports
  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  base_t          base = '0;
  mexp_pkg::exp_t exponent = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  mexp_pkg::mod_t power_mod;
  logic           modulus_wr_en = 1'b0;
  mexp_pkg::mod_t modulus_wr_data = '0;

  // Testbench state
  mexp_pkg::mod_t modulus_cfg = mexp_pkg::MODULUS_RESET;  // copy of the modulus register
  mexp_pkg::mod_t pending_powers[$];  // expected power_mod values, oldest first
  bit   gaps_on = 1'b0;
  bit   offer_held = 1'b0;            // in_valid left high for a following request
  int   hold_request = 0;             // long receiver hold, picked up by the receiver
  int   error_count = 0;
  int   sent_count = 0;
  int   checked_count = 0;
  int   setting_count = 1;

  modular_exponentiation uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .base            (base),
    .exponent        (exponent),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .power_mod       (power_mod),
    .modulus_wr_en   (modulus_wr_en),
    .modulus_wr_data (modulus_wr_data)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Square-and-multiply over all exponent bits, products kept at 64 bits
  function automatic mexp_pkg::mod_t calc_power_mod(base_t b, mexp_pkg::exp_t e,
                                                    mexp_pkg::mod_t m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mm;
    if (m < 2) return '0;  // modulus of zero or one: no nonzero residue
    mm  = 64'(m);
    acc = 64'd1;
    sq  = 64'(b) % mm;
    for (int i = 0; i < mexp_pkg::EXP_BITS; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return mexp_pkg::mod_t'(acc);
  endfunction

  // Receiver: random stall bursts, plus a long hold when one is requested
  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 6);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_result
    mexp_pkg::mod_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_powers.size() == 0) begin
        $error("power_mod: no request pending, actual %0d", power_mod);
        error_count++;
      end else begin
        want = pending_powers.pop_front();
        checked_count++;
        if (power_mod !== want) begin
          $error("power_mod: expected %0d, actual %0d", want, power_mod);
          error_count++;
        end
      end
    end
  end

  // Offer one request, hold it until taken, then maybe idle for a burst
  task automatic send_request(base_t b, mexp_pkg::exp_t e);
    int gap;
    base     <= b;
    exponent <= e;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_powers.push_back(calc_power_mod(b, e, modulus_cfg));
    sent_count++;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid   <= 1'b0;
      offer_held  = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      offer_held = 1'b1;
    end
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_results_drained();
    if (offer_held) begin
      in_valid   <= 1'b0;
      offer_held  = 1'b0;
    end
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  // Single-cycle modulus write; only called while the block is idle
  task automatic write_modulus(mexp_pkg::mod_t value);
    modulus_wr_data <= value;
    modulus_wr_en   <= 1'b1;
    @(posedge clk);
    modulus_wr_en <= 1'b0;
    modulus_cfg = value;
    setting_count++;
  endtask

  // Mostly wide random moduli, some small ones, powers of two and extremes
  function automatic mexp_pkg::mod_t pick_modulus();
    case ($urandom_range(0, 9))
      6, 7: return mexp_pkg::mod_t'($urandom_range(64, 2));
      8:    return mexp_pkg::mod_t'(1) << $urandom_range(26, 1);
      9: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return mexp_pkg::mod_t'(1);
          2:       return MODULUS_MAX;
          default: return mexp_pkg::MODULUS_RESET;
        endcase
      end
      default: return mexp_pkg::mod_t'($urandom_range(MODULUS_MAX, 2));
    endcase
  endfunction

  // Random request: edge bases and short exponents mixed with full-width ones
  task automatic send_random_request();
    base_t          b;
    mexp_pkg::exp_t e;
    case ($urandom_range(0, 7))
      0:       b = '0;
      1:       b = '1;
      2:       b = base_t'(modulus_cfg);      // residue zero
      3:       b = base_t'(modulus_cfg - 1);
      default: b = base_t'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       e = mexp_pkg::exp_t'($urandom_range(3, 0));
      1, 2:    e = mexp_pkg::exp_t'($urandom_range(255, 0));
      3:       e = mexp_pkg::exp_t'($urandom) >> $urandom_range(30, 0);
      default: e = mexp_pkg::exp_t'($urandom);
    endcase
    send_request(b, e);
  endtask

  // Modulus at its reset value; extremes of base and exponent
  task automatic test_reset_modulus();
    send_request('0, '0);                                  // zero to the zero is 1
    send_request('0, mexp_pkg::exp_t'(1));                 // zero base
    send_request('1, '0);                                  // zero exponent
    send_request('1, '1);
    send_request(base_t'(1), '1);
    send_request(base_t'(mexp_pkg::MODULUS_RESET), mexp_pkg::exp_t'(1));  // reduces to zero
    send_request(base_t'(mexp_pkg::MODULUS_RESET) + base_t'(1),
                 mexp_pkg::exp_t'(1));                     // exponent one still reduces
    send_request(base_t'(mexp_pkg::MODULUS_RESET - 1), mexp_pkg::exp_t'(2));
    send_request(base_t'(5),
                 mexp_pkg::exp_t'(mexp_pkg::MODULUS_RESET - 1));  // Fermat: result 1
    wait_results_drained();
  endtask

  // Smallest and largest moduli, degenerate moduli, a power of two
  task automatic test_modulus_extremes();
    write_modulus(mexp_pkg::mod_t'(2));
    send_request('1, '1);
    send_request(base_t'(6), mexp_pkg::exp_t'(3));
    wait_results_drained();
    write_modulus(MODULUS_MAX);
    send_request('1, '1);
    send_request(base_t'(MODULUS_MAX - 1), mexp_pkg::exp_t'(3));
    send_request(base_t'(3), '1);
    wait_results_drained();
    // modulus of one: every residue is zero
    write_modulus(mexp_pkg::mod_t'(1));
    send_request('1, '0);
    send_request(base_t'(5), mexp_pkg::exp_t'(7));
    wait_results_drained();
    // modulus of zero: result defined as zero
    write_modulus('0);
    send_request(base_t'(9), '0);
    send_request('1, '1);
    wait_results_drained();
    write_modulus(mexp_pkg::mod_t'(1) << 26);
    send_request(base_t'(3), mexp_pkg::exp_t'(1000));
    wait_results_drained();
  endtask

  // Receiver holds off long enough that a result waits and input stalls
  task automatic test_backpressure();
    write_modulus(pick_modulus());
    hold_request = LONG_HOLD;
    repeat (6) send_random_request();
    wait_results_drained();
  endtask

  // Random requests in phases; each phase has its own modulus and drains fully
  task automatic test_random_phases(int phases, int per_phase);
    repeat (phases) begin
      write_modulus(pick_modulus());
      repeat (per_phase) send_random_request();
      wait_results_drained();
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;
    test_reset_modulus();
    test_modulus_extremes();
    test_backpressure();
    test_random_phases(9, 32);
    // last part runs with both sides at full rate
    gaps_on = 1'b0;
    test_random_phases(1, 40);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests over %0d modulus settings, %0d results checked, %0d errors",
             sent_count, setting_count, checked_count, error_count);
    $display("Included degenerate moduli, a long output hold and full-width exponents");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin : watchdog
    #60_000_000;
    $display("Timeout with %0d results outstanding", pending_powers.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
